// ===== sv/asr_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the affine scale/rotation pipeline.
// No dependencies; used by the top level and its checker.
package asr_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int IN_W          = 32;
    localparam int DIFF_W        = IN_W + 1;
    localparam int PROD_W        = 2 * DIFF_W;
    localparam int CROSS_W       = PROD_W + 1;
    localparam int NORM_W        = 31;
    localparam int SQ_W          = 64;
    localparam int ROOT_STEPS    = 32;
    localparam int DIV_STEPS     = 32;
    localparam int LANES         = 2;
    localparam int GRP_W         = 8;
    localparam int GROUPS        = (CROSS_W + GRP_W - 1) / GRP_W;

    localparam logic [1:0] QUAD_0   = 2'd0;
    localparam logic [1:0] QUAD_90  = 2'd1;
    localparam logic [1:0] QUAD_180 = 2'd2;
    localparam logic [1:0] QUAD_270 = 2'd3;

    typedef struct packed {
        logic       bad;
        logic [1:0] quad;
    } meta_t;

endpackage

// ===== sv/affine_scale_rotation_from_points.sv =====
`timescale 1ns / 1ps
// Throughput: one point set per cycle; busy stays low, since nothing stalls.
// The depth is set by the 32-step square root and the 32-step divider,
// one step per stage, run as two lanes (x column and y column).
// Reset (rst_n low, asynchronous) clears all valid bits; no result follows.
// Depends on asr_pkg.
module affine_scale_rotation_from_points #(
    parameter int FRAC_BITS = asr_pkg::FRAC_BITS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic signed [31:0] pixel_a_x,
    input  logic signed [31:0] pixel_a_y,
    input  logic signed [31:0] pixel_b_x,
    input  logic signed [31:0] pixel_b_y,
    input  logic signed [31:0] pixel_c_x,
    input  logic signed [31:0] pixel_c_y,
    input  logic signed [31:0] machine_a_x,
    input  logic signed [31:0] machine_a_y,
    input  logic signed [31:0] machine_b_x,
    input  logic signed [31:0] machine_b_y,
    input  logic signed [31:0] machine_c_x,
    input  logic signed [31:0] machine_c_y,
    output logic               done,
    output logic [31:0]        scale_x,
    output logic [31:0]        scale_y,
    output logic [1:0]         angle_quadrant,
    output logic               ok
);

    localparam int DW = asr_pkg::NORM_W + FRAC_BITS;   // width of d << FRAC_BITS
    localparam int CW = asr_pkg::CROSS_W;
    localparam int L  = asr_pkg::LANES;
    localparam int G  = asr_pkg::GROUPS;
    localparam int RS = asr_pkg::ROOT_STEPS;
    localparam int DS = asr_pkg::DIV_STEPS;

    // The pipeline never stalls, so a word is taken whenever start is high.
    assign busy = 1'b0;
    logic accept;
    assign accept = start & ~busy;

    // ------------------------------------------------------------------
    // Stage 1: point differences B-A and C-A (33 bits, exact).
    // ------------------------------------------------------------------
    logic signed [32:0] dpx1_reg, dpy1_reg, dpx3_reg, dpy3_reg;
    logic signed [32:0] dmx1_reg, dmy1_reg, dmx3_reg, dmy3_reg;
    logic s1_vld_reg;

    always_ff @(posedge clk)
    begin
        dpx1_reg <= 33'(pixel_b_x)   - 33'(pixel_a_x);
        dpy1_reg <= 33'(pixel_b_y)   - 33'(pixel_a_y);
        dpx3_reg <= 33'(pixel_c_x)   - 33'(pixel_a_x);
        dpy3_reg <= 33'(pixel_c_y)   - 33'(pixel_a_y);
        dmx1_reg <= 33'(machine_b_x) - 33'(machine_a_x);
        dmy1_reg <= 33'(machine_b_y) - 33'(machine_a_y);
        dmx3_reg <= 33'(machine_c_x) - 33'(machine_a_x);
        dmy3_reg <= 33'(machine_c_y) - 33'(machine_a_y);
    end

    // ------------------------------------------------------------------
    // Stage 2: the ten cross products, one 33x33 multiplier each.
    // ------------------------------------------------------------------
    logic signed [65:0] p_det0_reg, p_det1_reg, p_n10_reg, p_n11_reg, p_n20_reg, p_n21_reg;
    logic signed [65:0] p_m10_reg, p_m11_reg, p_m20_reg, p_m21_reg;
    logic               dpy1_zero_s2_reg;
    logic               s2_vld_reg;

    always_ff @(posedge clk)
    begin
        p_det0_reg <= dpx3_reg * dpy1_reg;
        p_det1_reg <= dpy3_reg * dpx1_reg;
        p_n10_reg  <= dpy1_reg * dmx3_reg;
        p_n11_reg  <= dpy3_reg * dmx1_reg;
        p_n20_reg  <= dpy1_reg * dmy3_reg;
        p_n21_reg  <= dpy3_reg * dmy1_reg;
        p_m10_reg  <= dpx3_reg * dmx1_reg;
        p_m11_reg  <= dpx1_reg * dmx3_reg;
        p_m20_reg  <= dpx3_reg * dmy1_reg;
        p_m21_reg  <= dpx1_reg * dmy3_reg;
        dpy1_zero_s2_reg <= (dpy1_reg == '0);
    end

    // ------------------------------------------------------------------
    // Stage 3: determinant and the four numerators (67 bits, exact).
    // ------------------------------------------------------------------
    logic signed [CW-1:0] det_reg, n1_reg, n2_reg, m1_reg, m2_reg;
    logic                 dpy1_zero_s3_reg;
    logic                 s3_vld_reg;

    always_ff @(posedge clk)
    begin
        det_reg <= CW'(p_det0_reg) - CW'(p_det1_reg);
        n1_reg  <= CW'(p_n10_reg)  - CW'(p_n11_reg);
        n2_reg  <= CW'(p_n20_reg)  - CW'(p_n21_reg);
        m1_reg  <= CW'(p_m10_reg)  - CW'(p_m11_reg);
        m2_reg  <= CW'(p_m20_reg)  - CW'(p_m21_reg);
        dpy1_zero_s3_reg <= dpy1_zero_s2_reg;
    end

    // ------------------------------------------------------------------
    // Stage 4: magnitudes, degenerate flag, sign of cos.
    // Lane 0 works on N1/N2 (x column), lane 1 on M1/M2 (y column).
    // ------------------------------------------------------------------
    logic [CW-1:0] ad_s4_reg;
    logic [CW-1:0] ap_s4_reg [L];
    logic [CW-1:0] aq_s4_reg [L];
    logic          bad_s4_reg, cneg_s4_reg;
    logic          s4_vld_reg;

    always_ff @(posedge clk)
    begin
        ad_s4_reg    <= det_reg[CW-1] ? CW'(-det_reg) : CW'(det_reg);
        ap_s4_reg[0] <= n1_reg[CW-1]  ? CW'(-n1_reg)  : CW'(n1_reg);
        aq_s4_reg[0] <= n2_reg[CW-1]  ? CW'(-n2_reg)  : CW'(n2_reg);
        ap_s4_reg[1] <= m1_reg[CW-1]  ? CW'(-m1_reg)  : CW'(m1_reg);
        aq_s4_reg[1] <= m2_reg[CW-1]  ? CW'(-m2_reg)  : CW'(m2_reg);
        bad_s4_reg   <= (det_reg == '0) || dpy1_zero_s3_reg ||
                        ((n1_reg == '0) && (n2_reg == '0)) ||
                        ((m1_reg == '0) && (m2_reg == '0));
        cneg_s4_reg  <= n1_reg[CW-1] ^ det_reg[CW-1];
    end

    // ------------------------------------------------------------------
    // Stage 5: quadrant compare; first half of the leading-one search.
    // The bit length of the largest magnitude equals that of their OR,
    // so split the OR into byte groups and find the top bit in each.
    // ------------------------------------------------------------------
    asr_pkg::meta_t meta_s5_reg;
    logic [CW-1:0]  ad_s5_reg;
    logic [CW-1:0]  ap_s5_reg [L];
    logic [CW-1:0]  aq_s5_reg [L];
    logic [G-1:0]   grp_nz_reg  [L];
    logic [2:0]     grp_idx_reg [L][G];
    logic           s5_vld_reg;

    logic [G*asr_pkg::GRP_W-1:0] or_next [L];
    logic [G-1:0]                grp_nz_next  [L];
    logic [2:0]                  grp_idx_next [L][G];
    logic [1:0]                  quad_next;

    always_comb
    begin
        for (int ln = 0; ln < L; ln++)
        begin
            or_next[ln] = (G*asr_pkg::GRP_W)'(ad_s4_reg | ap_s4_reg[ln] | aq_s4_reg[ln]);
            for (int g = 0; g < G; g++)
            begin
                grp_nz_next[ln][g]  = |or_next[ln][g*asr_pkg::GRP_W +: asr_pkg::GRP_W];
                grp_idx_next[ln][g] = '0;
                for (int b = 0; b < asr_pkg::GRP_W; b++)
                begin
                    if (or_next[ln][g*asr_pkg::GRP_W + b])
                    begin
                        grp_idx_next[ln][g] = 3'(b);
                    end
                end
            end
        end
        // Within 45 deg of the x axis gives 0, beyond 135 gives 180, else 90.
        if (ap_s4_reg[0] > aq_s4_reg[0])
        begin
            quad_next = cneg_s4_reg ? asr_pkg::QUAD_180 : asr_pkg::QUAD_0;
        end
        else if (ap_s4_reg[0] == aq_s4_reg[0])
        begin
            quad_next = cneg_s4_reg ? asr_pkg::QUAD_90 : asr_pkg::QUAD_0;
        end
        else
        begin
            quad_next = asr_pkg::QUAD_90;
        end
    end

    always_ff @(posedge clk)
    begin
        meta_s5_reg.bad  <= bad_s4_reg;
        meta_s5_reg.quad <= quad_next;
        ad_s5_reg        <= ad_s4_reg;
        ap_s5_reg        <= ap_s4_reg;
        aq_s5_reg        <= aq_s4_reg;
        grp_nz_reg       <= grp_nz_next;
        grp_idx_reg      <= grp_idx_next;
    end

    // ------------------------------------------------------------------
    // Stage 6: pick the top group, giving the shift that brings the
    // largest magnitude below 2^31.
    // ------------------------------------------------------------------
    asr_pkg::meta_t meta_s6_reg;
    logic [CW-1:0]  ad_s6_reg;
    logic [CW-1:0]  ap_s6_reg [L];
    logic [CW-1:0]  aq_s6_reg [L];
    logic [6:0]     sh_reg    [L];
    logic           s6_vld_reg;

    logic [6:0] bl_next [L];
    logic [6:0] sh_next [L];

    always_comb
    begin
        for (int ln = 0; ln < L; ln++)
        begin
            bl_next[ln] = '0;
            for (int g = 0; g < G; g++)
            begin
                if (grp_nz_reg[ln][g])
                begin
                    bl_next[ln] = 7'(g * asr_pkg::GRP_W) + 7'(grp_idx_reg[ln][g]) + 7'd1;
                end
            end
            sh_next[ln] = (bl_next[ln] > 7'(asr_pkg::NORM_W))
                        ? bl_next[ln] - 7'(asr_pkg::NORM_W) : '0;
        end
    end

    always_ff @(posedge clk)
    begin
        meta_s6_reg <= meta_s5_reg;
        ad_s6_reg   <= ad_s5_reg;
        ap_s6_reg   <= ap_s5_reg;
        aq_s6_reg   <= aq_s5_reg;
        sh_reg      <= sh_next;
    end

    // ------------------------------------------------------------------
    // Stage 7: truncating right shift to 31-bit magnitudes.
    // ------------------------------------------------------------------
    asr_pkg::meta_t meta_s7_reg;
    logic [asr_pkg::NORM_W-1:0] d_s7_reg [L];
    logic [asr_pkg::NORM_W-1:0] u_s7_reg [L];
    logic [asr_pkg::NORM_W-1:0] v_s7_reg [L];
    logic                       s7_vld_reg;

    always_ff @(posedge clk)
    begin
        meta_s7_reg <= meta_s6_reg;
        for (int ln = 0; ln < L; ln++)
        begin
            d_s7_reg[ln] <= asr_pkg::NORM_W'(ad_s6_reg      >> sh_reg[ln]);
            u_s7_reg[ln] <= asr_pkg::NORM_W'(ap_s6_reg[ln] >> sh_reg[ln]);
            v_s7_reg[ln] <= asr_pkg::NORM_W'(aq_s6_reg[ln] >> sh_reg[ln]);
        end
    end

    // ------------------------------------------------------------------
    // Stage 8: squares.  Stage 9: sum of squares.
    // ------------------------------------------------------------------
    asr_pkg::meta_t meta_s8_reg;
    logic [asr_pkg::NORM_W-1:0]   d_s8_reg  [L];
    logic [2*asr_pkg::NORM_W-1:0] uu_s8_reg [L];
    logic [2*asr_pkg::NORM_W-1:0] vv_s8_reg [L];
    logic                         s8_vld_reg;

    always_ff @(posedge clk)
    begin
        meta_s8_reg <= meta_s7_reg;
        d_s8_reg    <= d_s7_reg;
        for (int ln = 0; ln < L; ln++)
        begin
            uu_s8_reg[ln] <= u_s7_reg[ln] * u_s7_reg[ln];
            vv_s8_reg[ln] <= v_s7_reg[ln] * v_s7_reg[ln];
        end
    end

    // Square-root pipe: index 0 is the sum stage, index k+1 the k-th step.
    asr_pkg::meta_t             meta_sq_reg [RS+1];
    logic [asr_pkg::NORM_W-1:0] d_sq_reg    [RS+1][L];
    logic [asr_pkg::SQ_W-1:0]   rad_sq_reg  [RS+1][L];
    logic [asr_pkg::SQ_W-1:0]   res_sq_reg  [RS+1][L];
    logic [RS:0]                sq_vld_reg;

    always_ff @(posedge clk)
    begin
        meta_sq_reg[0] <= meta_s8_reg;
        d_sq_reg[0]    <= d_s8_reg;
        for (int ln = 0; ln < L; ln++)
        begin
            rad_sq_reg[0][ln] <= asr_pkg::SQ_W'(uu_s8_reg[ln]) + asr_pkg::SQ_W'(vv_s8_reg[ln]);
            res_sq_reg[0][ln] <= '0;
        end
    end

    // One digit of the root per stage; the trial bit is fixed per stage.
    for (genvar k = 0; k < RS; k++)
    begin : g_root
        localparam logic [asr_pkg::SQ_W-1:0] BIT = asr_pkg::SQ_W'(1) << (62 - 2*k);
        logic [asr_pkg::SQ_W-1:0] trial_next [L];

        always_comb
        begin
            for (int ln = 0; ln < L; ln++)
            begin
                trial_next[ln] = res_sq_reg[k][ln] + BIT;
            end
        end

        always_ff @(posedge clk)
        begin
            meta_sq_reg[k+1] <= meta_sq_reg[k];
            d_sq_reg[k+1]    <= d_sq_reg[k];
            for (int ln = 0; ln < L; ln++)
            begin
                if (rad_sq_reg[k][ln] >= trial_next[ln])
                begin
                    rad_sq_reg[k+1][ln] <= rad_sq_reg[k][ln] - trial_next[ln];
                    res_sq_reg[k+1][ln] <= (res_sq_reg[k][ln] >> 1) + BIT;
                end
                else
                begin
                    rad_sq_reg[k+1][ln] <= rad_sq_reg[k][ln];
                    res_sq_reg[k+1][ln] <= res_sq_reg[k][ln] >> 1;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Divider entry: the quotient d*2^F / r overflows 32 bits exactly when
    // the part of d*2^F above bit 31 is at least r (also true for r = 0).
    // Otherwise that part is the starting remainder for 32 quotient steps.
    // ------------------------------------------------------------------
    asr_pkg::meta_t meta_dv_reg [DS+1];
    logic [31:0]    rem_dv_reg  [DS+1][L];
    logic [31:0]    dlo_dv_reg  [DS+1][L];
    logic [31:0]    den_dv_reg  [DS+1][L];
    logic [31:0]    quo_dv_reg  [DS+1][L];
    logic [L-1:0]   sat_dv_reg  [DS+1];
    logic [DS:0]    dv_vld_reg;

    logic [DW-1:0] num_next [L];
    logic [31:0]   root_next [L];
    logic [31:0]   hi_next   [L];

    always_comb
    begin
        for (int ln = 0; ln < L; ln++)
        begin
            num_next[ln]  = DW'(d_sq_reg[RS][ln]) << FRAC_BITS;
            root_next[ln] = 32'(res_sq_reg[RS][ln]);
            hi_next[ln]   = 32'(num_next[ln] >> 32);
        end
    end

    always_ff @(posedge clk)
    begin
        meta_dv_reg[0] <= meta_sq_reg[RS];
        for (int ln = 0; ln < L; ln++)
        begin
            rem_dv_reg[0][ln] <= hi_next[ln];
            dlo_dv_reg[0][ln] <= num_next[ln][31:0];
            den_dv_reg[0][ln] <= root_next[ln];
            quo_dv_reg[0][ln] <= '0;
            sat_dv_reg[0][ln] <= (hi_next[ln] >= root_next[ln]);
        end
    end

    // Restoring division, one quotient bit per stage.
    for (genvar k = 0; k < DS; k++)
    begin : g_div
        logic [32:0] part_next [L];
        logic [L-1:0] fit_next;

        always_comb
        begin
            for (int ln = 0; ln < L; ln++)
            begin
                part_next[ln] = {rem_dv_reg[k][ln], dlo_dv_reg[k][ln][31]};
                fit_next[ln]  = (part_next[ln] >= {1'b0, den_dv_reg[k][ln]});
            end
        end

        always_ff @(posedge clk)
        begin
            meta_dv_reg[k+1] <= meta_dv_reg[k];
            sat_dv_reg[k+1]  <= sat_dv_reg[k];
            for (int ln = 0; ln < L; ln++)
            begin
                rem_dv_reg[k+1][ln] <= fit_next[ln]
                                     ? 32'(part_next[ln] - {1'b0, den_dv_reg[k][ln]})
                                     : part_next[ln][31:0];
                dlo_dv_reg[k+1][ln] <= {dlo_dv_reg[k][ln][30:0], 1'b0};
                den_dv_reg[k+1][ln] <= den_dv_reg[k][ln];
                quo_dv_reg[k+1][ln] <= {quo_dv_reg[k][ln][30:0], fit_next[ln]};
            end
        end
    end

    // ------------------------------------------------------------------
    // Output register: saturate, and drop everything to zero on a
    // degenerate point set.
    // ------------------------------------------------------------------
    logic        done_reg;
    logic [31:0] scale_x_reg, scale_y_reg;
    logic [1:0]  quad_reg;
    logic        ok_reg;

    always_ff @(posedge clk)
    begin
        if (meta_dv_reg[DS].bad)
        begin
            scale_x_reg <= '0;
            scale_y_reg <= '0;
            quad_reg    <= asr_pkg::QUAD_0;
            ok_reg      <= 1'b0;
        end
        else
        begin
            scale_x_reg <= sat_dv_reg[DS][0] ? '1 : quo_dv_reg[DS][0];
            scale_y_reg <= sat_dv_reg[DS][1] ? '1 : quo_dv_reg[DS][1];
            quad_reg    <= meta_dv_reg[DS].quad;
            ok_reg      <= 1'b1;
        end
    end

    // Valid bits: the only state that reset clears.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg <= 1'b0;
            s2_vld_reg <= 1'b0;
            s3_vld_reg <= 1'b0;
            s4_vld_reg <= 1'b0;
            s5_vld_reg <= 1'b0;
            s6_vld_reg <= 1'b0;
            s7_vld_reg <= 1'b0;
            s8_vld_reg <= 1'b0;
            sq_vld_reg <= '0;
            dv_vld_reg <= '0;
            done_reg   <= 1'b0;
        end
        else
        begin
            s1_vld_reg <= accept;
            s2_vld_reg <= s1_vld_reg;
            s3_vld_reg <= s2_vld_reg;
            s4_vld_reg <= s3_vld_reg;
            s5_vld_reg <= s4_vld_reg;
            s6_vld_reg <= s5_vld_reg;
            s7_vld_reg <= s6_vld_reg;
            s8_vld_reg <= s7_vld_reg;
            sq_vld_reg <= {sq_vld_reg[RS-1:0], s8_vld_reg};
            dv_vld_reg <= {dv_vld_reg[DS-1:0], sq_vld_reg[RS]};
            done_reg   <= dv_vld_reg[DS];
        end
    end

    assign done           = done_reg;
    assign scale_x        = done_reg ? scale_x_reg : '0;
    assign scale_y        = done_reg ? scale_y_reg : '0;
    assign angle_quadrant = done_reg ? quad_reg : asr_pkg::QUAD_0;
    assign ok             = done_reg & ok_reg;

endmodule

// ===== sv/asr_checker.sv =====
`timescale 1ns / 1ps
// Port-level checks for the affine scale/rotation block, bound to the top.
// Depends on asr_pkg.
module asr_port_checks (
    input logic        clk,
    input logic        rst_n,
    input logic        busy,
    input logic        done,
    input logic [31:0] scale_x,
    input logic [31:0] scale_y,
    input logic [1:0]  angle_quadrant,
    input logic        ok
);

    a_never_busy: assert property (@(posedge clk) disable iff (!rst_n) !busy)
        else $error("busy raised on a pipeline that never stalls");

    a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !ok) |-> (scale_x == '0 && scale_y == '0 &&
                           angle_quadrant == asr_pkg::QUAD_0))
        else $error("degenerate word carries nonzero fields");

    a_no_270: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (angle_quadrant != asr_pkg::QUAD_270))
        else $error("quadrant 270 produced");

    a_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        !done |-> (!ok && scale_x == '0))
        else $error("result fields active without strobe");

endmodule

bind affine_scale_rotation_from_points asr_port_checks u_asr_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .busy           (busy),
    .done           (done),
    .scale_x        (scale_x),
    .scale_y        (scale_y),
    .angle_quadrant (angle_quadrant),
    .ok             (ok)
);
